### hdl/unit_normal_4d_cross_product_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the unit normal block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UNIT_NORMAL_4D_CROSS_PRODUCT_ASSERT_SVH
`define UNIT_NORMAL_4D_CROSS_PRODUCT_ASSERT_SVH

// same-cycle implication
`define UCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unit normal check failed");

// next-cycle implication
`define UCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unit normal check failed");

`endif

### hdl/ucp_pkg.sv
// ---------------------------------------------------------------------------
// ucp_pkg
// Shared constants and index helpers for the unit normal pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package ucp_pkg;

    localparam int COMP_BITS_DEF = 16;
    localparam int NORM_BITS     = 30;
    localparam int OUT_BITS      = 16;
    localparam int FRAC_BITS     = 15;
    localparam int SQ_W          = 2 * NORM_BITS;
    localparam int SUM_W         = SQ_W + 2;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int REM_W         = ROOT_W + 3;
    localparam int NUM_W         = NORM_BITS + FRAC_BITS + 1;

    localparam logic [OUT_BITS-1:0] Q15_MAX = 16'h7FFF;

    // column pairs of the 2x2 minors of rows B and C
    localparam int PAIR_LO [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_HI [6] = '{1, 2, 3, 2, 3, 3};

    function automatic int col_of(input int i, input int j);
        return (j < i) ? j : j + 1;
    endfunction

    function automatic int pair_of(input int x, input int y);
        int r;
        r = 0;
        for (int n = 0; n < 6; n++)
        begin
            if (PAIR_LO[n] == x && PAIR_HI[n] == y)
            begin
                r = n;
            end
        end
        return r;
    endfunction

    function automatic int pair_for(input int i, input int j);
        int c_lo;
        int c_hi;
        c_lo = col_of(i, (j == 0) ? 1 : 0);
        c_hi = col_of(i, (j == 2) ? 1 : 2);
        return pair_of(c_lo, c_hi);
    endfunction

endpackage

`default_nettype wire

### hdl/unit_normal_4d_cross_product.sv
// ---------------------------------------------------------------------------
// unit_normal_4d_cross_product
// Unit normal of three 4-component vectors as Q1.15 components.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one beat carries a_x..a_u, b_x..b_u, c_x..c_u, each
//   COMPONENT_BITS wide, packed from the lowest bits up.
//   Master channel m_*: one beat per input beat carrying n_x, n_y, n_z, n_u
//   (Q1.15) in m_tdata and the degenerate flag in m_tuser.
//   Throughput: one beat per cycle, sustained while m_tready stays high.
//   The pipeline from input accept to m_tvalid runs through the 31-stage
//   square root and the 16-stage divider.
//   Reset clears every valid bit; no beat is in flight afterwards.
//   When m_tready is low the output beat holds, one more beat lands in a skid
//   register, then s_tready drops and the whole pipeline freezes in place.
//   Degenerate inputs (all minors zero) give zero components, m_tuser = 1.
// ---------------------------------------------------------------------------
`default_nettype none
`include "unit_normal_4d_cross_product_assert.svh"

module unit_normal_4d_cross_product
    import ucp_pkg::*;
#(
    parameter int COMPONENT_BITS = COMP_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // a_x, a_y, a_z, a_u, b_x, b_y, b_z, b_u, c_x, c_y, c_z, c_u, zero pad
    input  logic [((12*COMPONENT_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // n_x, n_y, n_z, n_u
    output logic [4*OUT_BITS-1:0]                       m_tdata,
    // degenerate
    output logic                                        m_tuser
);

    localparam int W  = COMPONENT_BITS;
    localparam int KW = 3 * W + 1;

    logic                        en;
    logic                        k_valid;
    logic [4*KW-1:0]             k_data;
    logic                        nm_valid;
    logic [3:0][NORM_BITS-1:0]   nm_m;
    logic [3:0]                  nm_neg;
    logic                        nm_deg;
    logic                        rt_valid;
    logic [ROOT_W-1:0]           rt_len;
    logic [3:0][NORM_BITS-1:0]   rt_m;
    logic [3:0]                  rt_neg;
    logic                        rt_deg;
    logic                        pipe_valid;
    logic [4*OUT_BITS-1:0]       pipe_n;
    logic                        pipe_deg;
    logic                        pipe_go;

    logic                        out_v_reg;
    logic [4*OUT_BITS-1:0]       out_data_reg;
    logic                        out_deg_reg;
    logic                        skid_v_reg;
    logic [4*OUT_BITS-1:0]       skid_data_reg;
    logic                        skid_deg_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign pipe_go  = pipe_valid && en;

    ucp_minors #(.W(W)) u_minors
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata[12*W-1:0]),
        .out_valid (k_valid),
        .out_k     (k_data)
    );

    ucp_norm #(.W(W)) u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (k_valid),
        .in_k      (k_data),
        .out_valid (nm_valid),
        .out_m     (nm_m),
        .out_neg   (nm_neg),
        .out_deg   (nm_deg)
    );

    ucp_root u_root
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid),
        .in_m      (nm_m),
        .in_neg    (nm_neg),
        .in_deg    (nm_deg),
        .out_valid (rt_valid),
        .out_len   (rt_len),
        .out_m     (rt_m),
        .out_neg   (rt_neg),
        .out_deg   (rt_deg)
    );

    ucp_quot u_quot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .in_len    (rt_len),
        .in_m      (rt_m),
        .in_neg    (rt_neg),
        .in_deg    (rt_deg),
        .out_valid (pipe_valid),
        .out_n     (pipe_n),
        .out_deg   (pipe_deg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= pipe_go;
            end
        end
        else if (pipe_go)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_deg_reg  <= skid_deg_reg;
            end
            else
            begin
                out_data_reg <= pipe_n;
                out_deg_reg  <= pipe_deg;
            end
        end
        else if (pipe_go)
        begin
            skid_data_reg <= pipe_n;
            skid_deg_reg  <= pipe_deg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

    `UCP_ASSERT_IMP(a_skid_needs_out, skid_v_reg, out_v_reg)
    `UCP_ASSERT_IMP(a_deg_zero, out_v_reg && out_deg_reg, out_data_reg == '0)
    `UCP_ASSERT_NXT(a_skid_only_on_stall, !skid_v_reg && !(out_v_reg && !m_tready), !skid_v_reg)

endmodule

`default_nettype wire

### hdl/ucp_minors.sv
// ---------------------------------------------------------------------------
// ucp_minors
// Four-stage pipeline forming the signed 3x3 minors of rows A, B and C.
// ---------------------------------------------------------------------------
`default_nettype none

module ucp_minors
    import ucp_pkg::*;
#(
    parameter int W = COMP_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [12*W-1:0]        in_data,
    output logic                   out_valid,
    output logic [4*(3*W+1)-1:0]   out_k
);

    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;
    localparam int KW = 3 * W + 1;

    logic signed [W-1:0]  b_comp [4];
    logic signed [W-1:0]  c_comp [4];
    logic [3:0]           v_reg;
    logic [4*W-1:0]       a1_reg;
    logic [4*W-1:0]       a2_reg;
    logic signed [PW-1:0] p1_reg [6];
    logic signed [PW-1:0] p2_reg [6];
    logic signed [DW-1:0] d2_reg [6];
    logic signed [KW-1:0] t3_reg [4][3];
    logic signed [KW-1:0] k4_reg [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            b_comp[i] = in_data[(4+i)*W +: W];
            c_comp[i] = in_data[(8+i)*W +: W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= in_data[4*W-1:0];
            a2_reg <= a1_reg;
        end
    end

    for (genvar gp = 0; gp < 6; gp++)
    begin : g_pair
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_reg[gp] <= PW'(b_comp[PAIR_LO[gp]]) * PW'(c_comp[PAIR_HI[gp]]);
                p2_reg[gp] <= PW'(b_comp[PAIR_HI[gp]]) * PW'(c_comp[PAIR_LO[gp]]);
                d2_reg[gp] <= DW'(p1_reg[gp]) - DW'(p2_reg[gp]);
            end
        end
    end

    for (genvar gi = 0; gi < 4; gi++)
    begin : g_minor
        logic signed [KW-1:0] term_sgn [3];

        for (genvar gj = 0; gj < 3; gj++)
        begin : g_term
            localparam int  COL  = col_of(gi, gj);
            localparam int  PAIR = pair_for(gi, gj);
            localparam bit  NEGT = ((gj % 2) == 1) != ((gi % 2) == 0);
            logic signed [W-1:0] a_sel;

            assign a_sel = a2_reg[COL*W +: W];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t3_reg[gi][gj] <= KW'(a_sel) * KW'(d2_reg[PAIR]);
                end
            end

            assign term_sgn[gj] = NEGT ? -t3_reg[gi][gj] : t3_reg[gi][gj];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                k4_reg[gi] <= term_sgn[0] + term_sgn[1] + term_sgn[2];
            end
        end

        assign out_k[gi*KW +: KW] = k4_reg[gi];
    end

    assign out_valid = v_reg[3];

endmodule

`default_nettype wire

### hdl/ucp_norm.sv
// ---------------------------------------------------------------------------
// ucp_norm
// Magnitude, sign and zero detect, then a staged normalizing shift.
// ---------------------------------------------------------------------------
`default_nettype none

module ucp_norm
    import ucp_pkg::*;
#(
    parameter int W = COMP_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [4*(3*W+1)-1:0]        in_k,
    output logic                        out_valid,
    output logic [3:0][NORM_BITS-1:0]   out_m,
    output logic [3:0]                  out_neg,
    output logic                        out_deg
);

    localparam int KW       = 3 * W + 1;
    localparam int MW       = 3 * W;
    localparam int EW       = MW + NORM_BITS;
    localparam int SH_STEPS = $clog2(EW);

    logic [3:0][EW-1:0] ext_a;
    logic [3:0]         neg_a;
    logic [EW-1:0]      or_a;

    logic [3:0][EW-1:0] v_reg   [SH_STEPS+1];
    logic [EW-1:0]      o_reg   [SH_STEPS+1];
    logic [3:0]         n_reg   [SH_STEPS+1];
    logic               d_reg   [SH_STEPS+1];
    logic [SH_STEPS:0]  val_reg;

    always_comb
    begin
        logic [KW-1:0] kk;
        logic [KW-1:0] nk;
        or_a = '0;
        for (int i = 0; i < 4; i++)
        begin
            kk       = in_k[i*KW +: KW];
            nk       = -kk;
            neg_a[i] = kk[KW-1];
            ext_a[i] = EW'(kk[KW-1] ? nk[MW-1:0] : kk[MW-1:0]);
            or_a     = or_a | ext_a[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (en)
        begin
            val_reg <= {val_reg[SH_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0] <= ext_a;
            o_reg[0] <= or_a;
            n_reg[0] <= neg_a;
            d_reg[0] <= (or_a == '0);
        end
    end

    for (genvar gs = 0; gs < SH_STEPS; gs++)
    begin : g_shift
        localparam int AMT = 2 ** (SH_STEPS - 1 - gs);
        logic hold_top;

        assign hold_top = (o_reg[gs][EW-1 -: AMT] != '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    v_reg[gs+1][i] <= hold_top ? v_reg[gs][i] : (v_reg[gs][i] << AMT);
                end
                o_reg[gs+1] <= hold_top ? o_reg[gs] : (o_reg[gs] << AMT);
                n_reg[gs+1] <= n_reg[gs];
                d_reg[gs+1] <= d_reg[gs];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            out_m[i] = v_reg[SH_STEPS][i][EW-1 -: NORM_BITS];
        end
    end

    assign out_neg   = n_reg[SH_STEPS];
    assign out_deg   = d_reg[SH_STEPS];
    assign out_valid = val_reg[SH_STEPS];

endmodule

`default_nettype wire

### hdl/ucp_root.sv
// ---------------------------------------------------------------------------
// ucp_root
// Sum of squares, then a pipelined digit-by-digit integer square root.
// ---------------------------------------------------------------------------
`default_nettype none

module ucp_root
    import ucp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [3:0][NORM_BITS-1:0]   in_m,
    input  logic [3:0]                  in_neg,
    input  logic                        in_deg,
    output logic                        out_valid,
    output logic [ROOT_W-1:0]           out_len,
    output logic [3:0][NORM_BITS-1:0]   out_m,
    output logic [3:0]                  out_neg,
    output logic                        out_deg
);

    logic                        vq_reg;
    logic [3:0][SQ_W-1:0]        sq_reg;
    logic [3:0][NORM_BITS-1:0]   mq_reg;
    logic [3:0]                  nq_reg;
    logic                        dq_reg;

    logic [ROOT_W:0]             vr_reg;
    logic [REM_W-1:0]            rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]           root_reg [ROOT_W+1];
    logic [SUM_W-1:0]            sv_reg   [ROOT_W+1];
    logic [3:0][NORM_BITS-1:0]   m_reg    [ROOT_W+1];
    logic [3:0]                  n_reg    [ROOT_W+1];
    logic                        d_reg    [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vr_reg <= '0;
        end
        else if (en)
        begin
            vq_reg <= in_valid;
            vr_reg <= {vr_reg[ROOT_W-1:0], vq_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= SQ_W'(in_m[i]) * SQ_W'(in_m[i]);
            end
            mq_reg <= in_m;
            nq_reg <= in_neg;
            dq_reg <= in_deg;

            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            sv_reg[0]   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                         + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
            m_reg[0]    <= mq_reg;
            n_reg[0]    <= nq_reg;
            d_reg[0]    <= dq_reg;
        end
    end

    for (genvar gj = 0; gj < ROOT_W; gj++)
    begin : g_digit
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign cur   = {rem_reg[gj][REM_W-3:0], sv_reg[gj][SUM_W-1 -: 2]};
        assign trial = REM_W'({root_reg[gj], 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[gj+1]  <= ge ? (cur - trial) : cur;
                root_reg[gj+1] <= {root_reg[gj][ROOT_W-2:0], ge};
                sv_reg[gj+1]   <= sv_reg[gj] << 2;
                m_reg[gj+1]    <= m_reg[gj];
                n_reg[gj+1]    <= n_reg[gj];
                d_reg[gj+1]    <= d_reg[gj];
            end
        end
    end

    assign out_valid = vr_reg[ROOT_W];
    assign out_len   = root_reg[ROOT_W];
    assign out_m     = m_reg[ROOT_W];
    assign out_neg   = n_reg[ROOT_W];
    assign out_deg   = d_reg[ROOT_W];

endmodule

`default_nettype wire

### hdl/ucp_quot.sv
// ---------------------------------------------------------------------------
// ucp_quot
// Pipelined restoring division by the length, then sign and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module ucp_quot
    import ucp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ROOT_W-1:0]           in_len,
    input  logic [3:0][NORM_BITS-1:0]   in_m,
    input  logic [3:0]                  in_neg,
    input  logic                        in_deg,
    output logic                        out_valid,
    output logic [4*OUT_BITS-1:0]       out_n,
    output logic                        out_deg
);

    localparam int QW = OUT_BITS;

    logic [3:0][NUM_W-1:0]   num_a;

    logic [QW:0]             v_reg;
    logic [3:0][ROOT_W-1:0]  rem_reg [QW+1];
    logic [3:0][QW-1:0]      low_reg [QW+1];
    logic [3:0][QW-1:0]      q_reg   [QW+1];
    logic [ROOT_W-1:0]       len_reg [QW+1];
    logic [3:0]              n_reg   [QW+1];
    logic                    d_reg   [QW+1];
    logic                    vo_reg;
    logic [4*OUT_BITS-1:0]   n_out_reg;
    logic                    d_out_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            num_a[i] = NUM_W'({in_m[i], {FRAC_BITS{1'b0}}})
                     + NUM_W'(in_len[ROOT_W-1:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[QW-1:0], in_valid};
            vo_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[0][i] <= ROOT_W'(num_a[i][NUM_W-1:QW]);
                low_reg[0][i] <= num_a[i][QW-1:0];
                q_reg[0][i]   <= '0;
            end
            len_reg[0] <= in_len;
            n_reg[0]   <= in_neg;
            d_reg[0]   <= in_deg;
        end
    end

    for (genvar gb = 0; gb < QW; gb++)
    begin : g_step
        logic [3:0][ROOT_W:0]   cur;
        logic [3:0][ROOT_W:0]   dif;
        logic [3:0]             ge;

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                cur[i] = {rem_reg[gb][i], low_reg[gb][i][QW-1]};
                dif[i] = cur[i] - {1'b0, len_reg[gb]};
                ge[i]  = (cur[i] >= {1'b0, len_reg[gb]});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rem_reg[gb+1][i] <= ge[i] ? dif[i][ROOT_W-1:0] : cur[i][ROOT_W-1:0];
                    low_reg[gb+1][i] <= low_reg[gb][i] << 1;
                    q_reg[gb+1][i]   <= {q_reg[gb][i][QW-2:0], ge[i]};
                end
                len_reg[gb+1] <= len_reg[gb];
                n_reg[gb+1]   <= n_reg[gb];
                d_reg[gb+1]   <= d_reg[gb];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (d_reg[QW])
                begin
                    n_out_reg[i*OUT_BITS +: OUT_BITS] <= '0;
                end
                else if (n_reg[QW][i])
                begin
                    n_out_reg[i*OUT_BITS +: OUT_BITS] <= -q_reg[QW][i];
                end
                else
                begin
                    n_out_reg[i*OUT_BITS +: OUT_BITS] <=
                        (q_reg[QW][i] > Q15_MAX) ? Q15_MAX : q_reg[QW][i];
                end
            end
            d_out_reg <= d_reg[QW];
        end
    end

    assign out_valid = vo_reg;
    assign out_n     = n_out_reg;
    assign out_deg   = d_out_reg;

endmodule

`default_nettype wire
